/* design/prtc_pkg.sv */
// shared types, widths and codes for the pre-trade risk check
package prtc_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF = 16;

    localparam int MODE_W    = 2;
    localparam int VERDICT_W = 3;
    localparam int QTY_W     = 32;
    localparam int PRICE_W   = 32;
    localparam int POS_W     = 64;
    localparam int CASH_W    = 64;
    localparam int AMT_W     = QTY_W + PRICE_W;

    localparam int POS_LIM_W  = 40;
    localparam int SIZE_LIM_W = 32;
    localparam int LOSS_W     = 63;
    localparam int DEV_LIM_W  = 24;
    localparam int OPW_W      = 32;
    localparam int WIN_W      = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // deviation threshold and p&l widths
    localparam int THR_W = DEV_LIM_W + PRICE_W;
    localparam int MAG_W = POS_W + PRICE_W;
    localparam int PNL_W = MAG_W + 2;

    localparam int PNL_STAGES = 4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam logic [Q_AW:0] Q_CNT_FULL = Q_DEPTH[Q_AW:0];

    localparam logic [MODE_W-1:0] MODE_CHECK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DAY_RESET = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SET_PRICE = 2'd3;

    localparam logic [VERDICT_W-1:0] V_APPROVED = 3'd0;
    localparam logic [VERDICT_W-1:0] V_POSITION = 3'd1;
    localparam logic [VERDICT_W-1:0] V_SIZE     = 3'd2;
    localparam logic [VERDICT_W-1:0] V_LOSS     = 3'd3;
    localparam logic [VERDICT_W-1:0] V_PRICE    = 3'd4;
    localparam logic [VERDICT_W-1:0] V_RATE     = 3'd5;
    localparam logic [VERDICT_W-1:0] V_NO_PRICE = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 3'd5;

    localparam logic [POS_LIM_W-1:0]     POS_LIM_RST  = 40'd10000;
    localparam logic [SIZE_LIM_W-1:0]    SIZE_LIM_RST = 32'd1000;
    localparam logic signed [LOSS_W-1:0] LOSS_RST     = -63'sd1000000;
    localparam logic [DEV_LIM_W-1:0]     DEV_LIM_RST  = 24'd6554;
    localparam logic [OPW_W-1:0]         OPW_RST      = 32'd100;
    localparam logic [WIN_W-1:0]         WIN_LEN_RST  = 32'd1000000;

    typedef struct packed {
        logic [POS_LIM_W-1:0]     pos_lim;
        logic [SIZE_LIM_W-1:0]    size_lim;
        logic signed [LOSS_W-1:0] loss_floor;
        logic [DEV_LIM_W-1:0]     dev_lim;
        logic [OPW_W-1:0]         opw;
        logic [WIN_W-1:0]         win_len;
    } t_cfg;

    // one classified event, timestamp travels beside it
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               side;
        logic               is_limit;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
    } t_cmd;

    typedef struct packed {
        logic                    ok;
        logic signed [PNL_W-1:0] pnl;
        logic [THR_W-1:0]        thr;
    } t_pnl;

endpackage

/* design/prtc_if.sv */
// event and result channel interfaces
interface prtc_evt_if import prtc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic                 side;
    logic                 is_limit;
    logic [QTY_W-1:0]     quantity;
    logic [PRICE_W-1:0]   price;
    logic [TIME_BITS-1:0] timestamp;

    modport source (
        output valid, mode, side, is_limit, quantity, price, timestamp,
        input  ready
    );
    modport sink (
        input  valid, mode, side, is_limit, quantity, price, timestamp,
        output ready
    );
endinterface

interface prtc_res_if import prtc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [VERDICT_W-1:0]    verdict;
    logic                    kill_switch;
    logic signed [POS_W-1:0] position_now;

    modport source (
        output valid, verdict, kill_switch, position_now,
        input  ready
    );
    modport sink (
        input  valid, verdict, kill_switch, position_now,
        output ready
    );
endinterface

/* design/prtc_front.sv */
// front stage: takes event beats and precomputes the fill amount
module prtc_front import prtc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    prtc_evt_if.sink             i_evt,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output logic [TIME_BITS-1:0] o_ts
);

    logic                 r_fv;
    logic                 n_fv;
    t_cmd                 r_cmd;
    logic [TIME_BITS-1:0] r_ts;
    logic                 take;

    assign i_evt.ready = !r_fv || !i_q_full;
    assign take        = i_evt.valid && i_evt.ready;
    assign o_push      = r_fv && !i_q_full;
    assign o_cmd       = r_cmd;
    assign o_ts        = r_ts;

    always_comb begin
        n_fv = r_fv;
        if (take) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    // trade value of a fill, quantity times price
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.mode     <= i_evt.mode;
            r_cmd.side     <= i_evt.side;
            r_cmd.is_limit <= i_evt.is_limit;
            r_cmd.qty      <= i_evt.quantity;
            r_cmd.price    <= i_evt.price;
            r_cmd.amount   <= AMT_W'(i_evt.quantity) * AMT_W'(i_evt.price);
            r_ts           <= i_evt.timestamp;
        end
    end

endmodule

/* design/prtc_queue.sv */
// small fifo between front and back
module prtc_queue import prtc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_cmd                 i_cmd,
    input  logic [TIME_BITS-1:0] i_ts,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output t_cmd                 o_cmd,
    output logic [TIME_BITS-1:0] o_ts
);

    t_cmd                 r_cmd_q [Q_DEPTH];
    logic [TIME_BITS-1:0] r_ts_q  [Q_DEPTH];
    logic [Q_AW-1:0]      r_wp;
    logic [Q_AW-1:0]      r_rp;
    logic [Q_AW:0]        r_cnt;

    assign o_full  = (r_cnt == Q_CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_cmd_q[r_rp];
    assign o_ts    = r_ts_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_q[r_wp] <= i_cmd;
            r_ts_q[r_wp]  <= i_ts;
        end
    end

endmodule

/* design/prtc_pnl.sv */
// p&l and deviation threshold pipeline, refreshed after every state change
module prtc_pnl import prtc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mut,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [CASH_W-1:0]    i_cash,
    input  logic [PRICE_W-1:0]   i_last,
    input  logic [DEV_LIM_W-1:0] i_dev_lim,
    output t_pnl                 o_pnl
);

    localparam int HALF = POS_W / 2;

    logic [PNL_STAGES-1:0] r_busy;

    logic                 r_s1_neg;
    logic [POS_W-1:0]     r_s1_mag;
    logic [PRICE_W-1:0]   r_s1_last;
    logic [CASH_W-1:0]    r_s1_cash;
    logic [DEV_LIM_W-1:0] r_s1_dev;

    logic                 r_s2_neg;
    logic [AMT_W-1:0]     r_s2_plo;
    logic [AMT_W-1:0]     r_s2_phi;
    logic [THR_W-1:0]     r_s2_thr;
    logic [CASH_W-1:0]    r_s2_cash;

    logic                 r_s3_neg;
    logic [MAG_W-1:0]     r_s3_mag;
    logic [THR_W-1:0]     r_s3_thr;
    logic [CASH_W-1:0]    r_s3_cash;

    logic [PNL_W-1:0]     r_pnl;
    logic [THR_W-1:0]     r_thr;

    logic [PNL_W-1:0]     cash_ext;
    logic [PNL_W-1:0]     mag_ext;

    // results are good once no change is still in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '1;
        end else begin
            r_busy <= {r_busy[PNL_STAGES-2:0], i_mut};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg  <= i_pos[POS_W-1];
        r_s1_mag  <= i_pos[POS_W-1] ? (~i_pos + POS_W'(1)) : i_pos;
        r_s1_last <= i_last;
        r_s1_cash <= i_cash;
        r_s1_dev  <= i_dev_lim;

        r_s2_neg  <= r_s1_neg;
        r_s2_plo  <= AMT_W'(r_s1_mag[HALF-1:0]) * AMT_W'(r_s1_last);
        r_s2_phi  <= AMT_W'(r_s1_mag[POS_W-1:HALF]) * AMT_W'(r_s1_last);
        r_s2_thr  <= THR_W'(r_s1_dev) * THR_W'(r_s1_last);
        r_s2_cash <= r_s1_cash;

        r_s3_neg  <= r_s2_neg;
        r_s3_mag  <= {r_s2_phi, {HALF{1'b0}}} + MAG_W'(r_s2_plo);
        r_s3_thr  <= r_s2_thr;
        r_s3_cash <= r_s2_cash;

        r_pnl     <= r_s3_neg ? (cash_ext - mag_ext) : (cash_ext + mag_ext);
        r_thr     <= r_s3_thr;
    end

    assign cash_ext = {{(PNL_W-CASH_W){r_s3_cash[CASH_W-1]}}, r_s3_cash};
    assign mag_ext  = PNL_W'(r_s3_mag);

    assign o_pnl.ok  = ~|r_busy;
    assign o_pnl.pnl = $signed(r_pnl);
    assign o_pnl.thr = r_thr;

endmodule

/* design/prtc_back.sv */
// back stage: holds the book state, runs checks and fills, drives results
module prtc_back import prtc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_cmd                 i_cmd,
    input  logic [TIME_BITS-1:0] i_ts,
    input  t_cfg                 i_cfg,
    input  t_pnl                 i_pnl,
    output logic                 o_pop,
    output logic                 o_mut,
    output logic [POS_W-1:0]     o_pos,
    output logic [CASH_W-1:0]    o_cash,
    output logic [PRICE_W-1:0]   o_last,
    prtc_res_if.source           o_res
);

    localparam int EL_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
    localparam logic [POS_W-1:0] S64_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] S64_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic [POS_W-1:0]     r_pos,    n_pos;
    logic [CASH_W-1:0]    r_cash,   n_cash;
    logic [PRICE_W-1:0]   r_last,   n_last;
    logic                 r_breach, n_breach;
    logic [OPW_W-1:0]     r_wcount, n_wcount;
    logic [TIME_BITS-1:0] r_wstart, n_wstart;

    logic                 r_ov;
    logic [VERDICT_W-1:0] r_verdict;
    logic                 r_kill;
    logic [POS_W-1:0]     r_posn;

    logic                 fire;
    logic [POS_W:0]       pos_sum;
    logic [POS_W:0]       lim_ext;
    logic [CASH_W+1:0]    cash_sum;
    logic [POS_W-1:0]     pos_sat;
    logic [CASH_W-1:0]    cash_sat;
    logic [PNL_W-1:0]     floor_ext;
    logic                 loss_hit;
    logic                 pos_bad;
    logic [PRICE_W-1:0]   diff;
    logic [THR_W-1:0]     diff_sh;
    logic                 dev_bad;
    logic [TIME_BITS-1:0] elapsed;
    logic                 restart;
    logic [OPW_W-1:0]     cnt_eff;
    logic                 rate_bad;
    logic [VERDICT_W-1:0] chk_verdict;
    logic                 breach_set;
    logic                 rate_reached;

    assign fire  = i_q_valid && (!r_ov || o_res.ready)
                   && ((i_cmd.mode != MODE_CHECK) || i_pnl.ok);
    assign o_pop = fire;
    assign o_mut = fire && (i_cmd.mode != MODE_CHECK);

    assign o_pos  = r_pos;
    assign o_cash = r_cash;
    assign o_last = r_last;

    // position after the event, one bit of headroom
    assign pos_sum = i_cmd.side
                     ? ({r_pos[POS_W-1], r_pos} - (POS_W+1)'(i_cmd.qty))
                     : ({r_pos[POS_W-1], r_pos} + (POS_W+1)'(i_cmd.qty));
    assign pos_sat = (pos_sum[POS_W] != pos_sum[POS_W-1])
                     ? (pos_sum[POS_W] ? S64_MIN : S64_MAX)
                     : pos_sum[POS_W-1:0];

    // cash moves opposite to position
    assign cash_sum = i_cmd.side
                      ? ({{2{r_cash[CASH_W-1]}}, r_cash} + (CASH_W+2)'(i_cmd.amount))
                      : ({{2{r_cash[CASH_W-1]}}, r_cash} - (CASH_W+2)'(i_cmd.amount));
    assign cash_sat = ((cash_sum[CASH_W+1:CASH_W-1] != 3'b000)
                       && (cash_sum[CASH_W+1:CASH_W-1] != 3'b111))
                      ? (cash_sum[CASH_W+1] ? S64_MIN : S64_MAX)
                      : cash_sum[CASH_W-1:0];

    assign floor_ext = {{(PNL_W-LOSS_W){i_cfg.loss_floor[LOSS_W-1]}}, i_cfg.loss_floor};
    assign loss_hit  = i_pnl.pnl <= $signed(floor_ext);

    assign lim_ext = (POS_W+1)'(i_cfg.pos_lim);
    assign pos_bad = ($signed(pos_sum) > $signed(lim_ext))
                     || ($signed(pos_sum) < -$signed(lim_ext));

    assign diff    = (i_cmd.price > r_last) ? (i_cmd.price - r_last) : (r_last - i_cmd.price);
    assign diff_sh = THR_W'({diff, {FRAC_BITS{1'b0}}});
    assign dev_bad = diff_sh > i_pnl.thr;

    assign elapsed  = i_ts - r_wstart;
    assign restart  = EL_W'(elapsed) >= EL_W'(i_cfg.win_len);
    assign cnt_eff  = restart ? '0 : r_wcount;
    assign rate_bad = cnt_eff >= i_cfg.opw;

    always_comb begin
        chk_verdict  = V_APPROVED;
        breach_set   = 1'b0;
        rate_reached = 1'b0;
        priority if (r_breach) begin
            chk_verdict = V_LOSS;
        end else if (loss_hit) begin
            chk_verdict = V_LOSS;
            breach_set  = 1'b1;
        end else if (i_cmd.qty > i_cfg.size_lim) begin
            chk_verdict = V_SIZE;
        end else if (pos_bad) begin
            chk_verdict = V_POSITION;
        end else if (i_cmd.is_limit && (r_last == '0)) begin
            chk_verdict = V_NO_PRICE;
        end else if (i_cmd.is_limit && dev_bad) begin
            chk_verdict = V_PRICE;
        end else begin
            rate_reached = 1'b1;
            if (rate_bad) begin
                chk_verdict = V_RATE;
            end
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_cash   = r_cash;
        n_last   = r_last;
        n_breach = r_breach;
        n_wcount = r_wcount;
        n_wstart = r_wstart;
        if (fire) begin
            unique case (i_cmd.mode)
                MODE_CHECK: begin
                    if (breach_set) begin
                        n_breach = 1'b1;
                    end
                    if (rate_reached) begin
                        if (restart) begin
                            n_wstart = i_ts;
                        end
                        n_wcount = rate_bad ? cnt_eff : (cnt_eff + OPW_W'(1));
                    end
                end
                MODE_FILL: begin
                    n_pos  = pos_sat;
                    n_cash = cash_sat;
                end
                MODE_DAY_RESET: begin
                    n_cash   = '0;
                    n_breach = 1'b0;
                end
                MODE_SET_PRICE: begin
                    n_last = i_cmd.price;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cash   <= '0;
            r_last   <= '0;
            r_breach <= 1'b0;
            r_wcount <= '0;
            r_wstart <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_cash   <= n_cash;
            r_last   <= n_last;
            r_breach <= n_breach;
            r_wcount <= n_wcount;
            r_wstart <= n_wstart;
            if (fire) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_verdict <= (i_cmd.mode == MODE_CHECK) ? chk_verdict : V_APPROVED;
            r_kill    <= n_breach;
            r_posn    <= n_pos;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.verdict      = r_verdict;
    assign o_res.kill_switch  = r_kill;
    assign o_res.position_now = $signed(r_posn);

endmodule

/* design/pre_trade_risk_check.sv */
// pre-trade risk check top level: config registers, front, queue, p&l pipeline, back
// path: front register, then queue, then the back stage registers the result beat
// throughput: one event per cycle while the result channel is not stalled; a check
//   behind a fill, day reset, price update or config write waits for the p&l multiply pipeline
// reset: synchronous active low, clears position, cash, last price, kill switch and
//   rate window, loads default limits; no clearing pass, ready right after reset
module pre_trade_risk_check import prtc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    prtc_evt_if.sink              i_evt,
    prtc_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // limits; the user must write them only while the block is idle, the block does not enforce it
    t_cfg r_cfg;

    // front to queue
    logic                 push;
    t_cmd                 f_cmd;
    logic [TIME_BITS-1:0] f_ts;

    // queue to back
    logic                 q_full;
    logic                 q_valid;
    t_cmd                 q_cmd;
    logic [TIME_BITS-1:0] q_ts;
    logic                 pop;

    // state snapshot feeding the p&l pipeline
    logic                 back_mut;
    logic                 pnl_mut;
    logic [POS_W-1:0]     pos;
    logic [CASH_W-1:0]    cash;
    logic [PRICE_W-1:0]   last;
    t_pnl                 pnl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_lim    <= POS_LIM_RST;
            r_cfg.size_lim   <= SIZE_LIM_RST;
            r_cfg.loss_floor <= LOSS_RST;
            r_cfg.dev_lim    <= DEV_LIM_RST;
            r_cfg.opw        <= OPW_RST;
            r_cfg.win_len    <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POS_LIM:  r_cfg.pos_lim    <= i_cfg_data[POS_LIM_W-1:0];
                CFG_SIZE_LIM: r_cfg.size_lim   <= i_cfg_data[SIZE_LIM_W-1:0];
                CFG_LOSS:     r_cfg.loss_floor <= $signed(i_cfg_data[LOSS_W-1:0]);
                CFG_DEV_LIM:  r_cfg.dev_lim    <= i_cfg_data[DEV_LIM_W-1:0];
                CFG_OPW:      r_cfg.opw        <= i_cfg_data[OPW_W-1:0];
                CFG_WIN_LEN:  r_cfg.win_len    <= i_cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a config write also invalidates the threshold and p&l pipeline
    assign pnl_mut = back_mut || i_cfg_we;

    prtc_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (i_evt),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_ts     (f_ts)
    );

    prtc_queue #(
        .TIME_BITS (TIME_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_ts    (f_ts),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_ts    (q_ts)
    );

    prtc_pnl u_pnl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mut     (pnl_mut),
        .i_pos     (pos),
        .i_cash    (cash),
        .i_last    (last),
        .i_dev_lim (r_cfg.dev_lim),
        .o_pnl     (pnl)
    );

    prtc_back #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .i_ts      (q_ts),
        .i_cfg     (r_cfg),
        .i_pnl     (pnl),
        .o_pop     (pop),
        .o_mut     (back_mut),
        .o_pos     (pos),
        .o_cash    (cash),
        .o_last    (last),
        .o_res     (o_res)
    );

endmodule
